>>> sv/mau_pkg.sv
// Package with the item types, operation codes, and shared constants of the modular arithmetic unit.
package mau_pkg;

  localparam int unsigned MOD_W = 31;
  localparam int unsigned EXP_W = 63;
  localparam int unsigned RAW_W = 64;
  localparam int unsigned EXP_BITS_DEF = 64;
  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  // Operation codes.
  localparam logic [2:0] OP_REDUCE = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_INV    = 3'd5;
  localparam logic [2:0] OP_NEG    = 3'd6;
  localparam logic [2:0] OP_POW    = 3'd7;

  typedef struct packed {
    logic [2:0]        operation;
    logic [MOD_W-1:0]  operand_a;
    logic [MOD_W-1:0]  operand_b;
    logic [EXP_W-1:0]  exponent;
    logic signed [RAW_W-1:0] raw_value;
  } in_item_t;

  typedef struct packed {
    logic [MOD_W-1:0] result;
    logic             no_inverse;
  } out_item_t;

  // Datapath micro-operations started by the controller.
  localparam logic [3:0] DP_LOAD    = 4'd0;  // latch item, start reducing a
  localparam logic [3:0] DP_REDB    = 4'd1;  // start reducing b
  localparam logic [3:0] DP_REDRAW  = 4'd2;  // start reducing raw magnitude
  localparam logic [3:0] DP_MUL     = 4'd3;  // start acc = acc * a mod m (b * a for multiply)
  localparam logic [3:0] DP_SQR     = 4'd4;  // start a = a * a mod m
  localparam logic [3:0] DP_INVA    = 4'd5;  // start Euclid on a
  localparam logic [3:0] DP_INVB    = 4'd6;  // start Euclid on b
  localparam logic [3:0] DP_SIMPLE  = 4'd7;  // add, sub, neg on a and b
  localparam logic [3:0] DP_FIXRAW  = 4'd8;  // sign correction of reduce
  localparam logic [3:0] DP_NOP     = 4'd9;

  typedef struct packed {
    logic       start;
    logic [3:0] cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       exp_bit;
    logic       exp_done;
    logic       inv_fail;
    logic [2:0] op;
  } dp_sts_t;

endpackage

>>> sv/mau_divider.sv
// Restoring divider: remainder of a 64-bit dividend by a 31-bit divisor, with the quotient.
module mau_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [63:0]                  dividend,
  input  logic [mau_pkg::MOD_W-1:0]    divisor,
  output logic                         busy,
  output logic [63:0]                  quotient,
  output logic [mau_pkg::MOD_W-1:0]    remainder
);

  logic [63:0]               quo_r, quo_nxt;
  logic [mau_pkg::MOD_W:0]   rem_r, rem_nxt;
  logic [mau_pkg::MOD_W-1:0] div_r;
  logic [6:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic [mau_pkg::MOD_W+1:0] trial;

  // One quotient bit per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[63]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {2'b00, div_r}) begin
        rem_nxt = (mau_pkg::MOD_W+1)'(trial - {2'b00, div_r});
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[mau_pkg::MOD_W:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 7'd1;
      busy_nxt = (cnt_r != 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) div_r <= divisor;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[mau_pkg::MOD_W-1:0];

endmodule

>>> sv/mau_datapath.sv
// Datapath: operand registers, multiplier, shared divider and the Euclid step.
module mau_datapath #(
  parameter int unsigned EXP_BITS = mau_pkg::EXP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mau_pkg::MOD_W-1:0]    modulus,
  input  mau_pkg::in_item_t            item,
  input  mau_pkg::dp_cmd_t             cmd,
  output mau_pkg::dp_sts_t             sts,
  output mau_pkg::out_item_t           res
);

  localparam int unsigned MW = mau_pkg::MOD_W;
  localparam int unsigned CW = MW + 2;  // signed Bezout coefficient width

  // Sub-steps of the datapath's own small sequencer.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_REDA   = 4'd1;
  localparam logic [3:0] S_REDB   = 4'd2;
  localparam logic [3:0] S_REDRAW = 4'd3;
  localparam logic [3:0] S_MULP   = 4'd4;
  localparam logic [3:0] S_MULD   = 4'd5;
  localparam logic [3:0] S_EUDIV  = 4'd6;
  localparam logic [3:0] S_EUUPD  = 4'd7;
  localparam logic [3:0] S_EUFIN  = 4'd8;
  localparam logic [3:0] S_EUMUL  = 4'd9;

  logic [3:0]     st_r;
  logic [MW-1:0]  m_r, a_r, b_r, acc_r;
  logic [2:0]     op_r;
  logic [EXP_BITS-1:0] exp_r;
  logic [6:0]     ecnt_r;
  logic           neg_r, fail_r;
  logic [63:0]    raw_r;
  logic           mul_sq_r;
  logic [2*MW-1:0] prod_r;
  // Euclid state: x, y and coefficients cx, cy.
  logic [MW-1:0]  ex_r, ey_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [CW+MW:0] qc;
  logic signed [CW-1:0]  cy_fix;

  logic           dv_start, dv_busy;
  logic [63:0]    dv_dividend, dv_quo;
  logic [MW-1:0]  dv_divisor, dv_rem;
  logic [MW:0]    sum;
  logic [MW-1:0]  diff;
  logic [MW-1:0]  mod_eff;

  assign mod_eff = (modulus < MW'(2)) ? MW'(2) : modulus;

  mau_divider u_div (
    .clk, .rst_n, .start(dv_start), .dividend(dv_dividend), .divisor(dv_divisor),
    .busy(dv_busy), .quotient(dv_quo), .remainder(dv_rem)
  );

  // Divider request, chosen by the step being started.
  always_comb begin
    dv_start    = 1'b0;
    dv_dividend = {{(64-MW){1'b0}}, item.operand_a};
    dv_divisor  = mod_eff;
    if (cmd.start) begin
      unique case (cmd.cmd)
        mau_pkg::DP_LOAD: begin
          dv_start = 1'b1;
        end
        mau_pkg::DP_REDB: begin
          dv_start = 1'b1; dv_dividend = {{(64-MW){1'b0}}, b_r}; dv_divisor = m_r;
        end
        mau_pkg::DP_REDRAW: begin
          dv_start = 1'b1; dv_dividend = raw_r; dv_divisor = m_r;
        end
        default: ;
      endcase
    end else if (st_r == S_MULP) begin
      dv_start = 1'b1; dv_dividend = {{(64-2*MW){1'b0}}, prod_r}; dv_divisor = m_r;
    end else if (st_r == S_EUUPD && ex_r != '0) begin
      dv_start = 1'b1; dv_dividend = {{(64-MW){1'b0}}, ey_r}; dv_divisor = ex_r;
    end
  end

  assign sum  = {1'b0, a_r} + {1'b0, b_r};
  assign diff = (a_r >= b_r) ? (a_r - b_r) : MW'({1'b0, a_r} + {1'b0, m_r} - {1'b0, b_r});
  assign qc   = $signed({1'b0, dv_quo[MW-1:0]}) * cx_r;
  assign cy_fix = (cy_r < 0) ? CW'(cy_r + $signed({2'b00, m_r})) : cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      fail_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (cmd.start) begin
            unique case (cmd.cmd)
              mau_pkg::DP_LOAD: begin
                m_r   <= mod_eff;
                op_r  <= item.operation;
                b_r   <= item.operand_b;
                exp_r <= EXP_BITS'(item.exponent);
                neg_r <= item.raw_value[63];
                raw_r <= item.raw_value[63] ? (~item.raw_value + 64'd1)
                                            : item.raw_value;
                acc_r <= MW'(1);
                ecnt_r <= '0;
                fail_r <= 1'b0;
                st_r  <= S_REDA;
              end
              mau_pkg::DP_REDB:   st_r <= S_REDB;
              mau_pkg::DP_REDRAW: st_r <= S_REDRAW;
              // Multiply takes a * b; the power loop takes acc * a.
              mau_pkg::DP_MUL: begin
                prod_r <= ((op_r == mau_pkg::OP_MUL) ? b_r : acc_r) * a_r;
                mul_sq_r <= 1'b0; st_r <= S_MULP;
              end
              mau_pkg::DP_SQR: begin
                prod_r <= a_r * a_r; mul_sq_r <= 1'b1; st_r <= S_MULP;
                exp_r <= exp_r >> 1; ecnt_r <= ecnt_r + 7'd1;
              end
              mau_pkg::DP_INVA, mau_pkg::DP_INVB: begin
                ex_r <= (cmd.cmd == mau_pkg::DP_INVA) ? a_r : b_r;
                ey_r <= m_r; cx_r <= CW'(1); cy_r <= '0;
                st_r <= S_EUUPD;
              end
              mau_pkg::DP_SIMPLE: begin
                unique case (op_r)
                  mau_pkg::OP_ADD: acc_r <= (sum >= {1'b0, m_r}) ?
                                     MW'(sum - {1'b0, m_r}) : sum[MW-1:0];
                  mau_pkg::OP_SUB: acc_r <= diff;
                  mau_pkg::OP_NEG: acc_r <= (a_r == '0) ? '0 : m_r - a_r;
                  default:         acc_r <= a_r;
                endcase
              end
              mau_pkg::DP_FIXRAW: acc_r <= (neg_r && a_r != '0) ? m_r - a_r : a_r;
              default: ;
            endcase
          end
        end
        // Reductions land in a_r, b_r or a_r respectively.
        S_REDA:   if (!dv_busy) begin a_r <= dv_rem; st_r <= S_IDLE; end
        S_REDB:   if (!dv_busy) begin b_r <= dv_rem; st_r <= S_IDLE; end
        S_REDRAW: if (!dv_busy) begin a_r <= dv_rem; st_r <= S_IDLE; end
        S_MULP:   st_r <= S_MULD;
        S_MULD: begin
          if (!dv_busy) begin
            if (mul_sq_r) a_r <= dv_rem; else acc_r <= dv_rem;
            st_r <= S_IDLE;
          end
        end
        // Euclid: start a division y / x, or finish when x is zero.
        S_EUUPD: begin
          if (ex_r == '0) st_r <= S_EUFIN;
          else st_r <= S_EUDIV;
        end
        S_EUDIV: begin
          if (!dv_busy) begin
            ey_r <= ex_r; ex_r <= dv_rem;
            cy_r <= cx_r; cx_r <= CW'(cy_r - CW'(qc));
            st_r <= S_EUUPD;
          end
        end
        S_EUFIN: begin
          if (ey_r != MW'(1)) begin
            fail_r <= 1'b1; acc_r <= '0; st_r <= S_IDLE;
          end else if (op_r == mau_pkg::OP_INV) begin
            acc_r <= cy_fix[MW-1:0]; st_r <= S_IDLE;
          end else begin
            acc_r <= cy_fix[MW-1:0]; st_r <= S_EUMUL;
          end
        end
        S_EUMUL: begin
          prod_r <= acc_r * a_r; mul_sq_r <= 1'b0; st_r <= S_MULP;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign sts.busy     = (st_r != S_IDLE);
  assign sts.exp_bit  = exp_r[0];
  assign sts.exp_done = (exp_r == '0) || (ecnt_r == 7'(EXP_BITS));
  assign sts.inv_fail = fail_r;
  assign sts.op       = op_r;
  assign res.result     = acc_r;
  assign res.no_inverse = fail_r;

endmodule

>>> sv/mau_control.sv
// Controller: sequences the datapath steps for each item and runs the handshakes.
module mau_control (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  mau_pkg::dp_sts_t sts,
  output mau_pkg::dp_cmd_t cmd,
  output logic             capture
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_RA   = 3'd1;  // a being reduced
  localparam logic [2:0] C_RB   = 3'd2;  // b being reduced
  localparam logic [2:0] C_EXEC = 3'd3;  // dispatch on the operation
  localparam logic [2:0] C_POW  = 3'd4;  // square-and-multiply loop
  localparam logic [2:0] C_SQ   = 3'd5;  // squaring step pending
  localparam logic [2:0] C_FIX  = 3'd6;  // reduce sign fix
  localparam logic [2:0] C_DONE = 3'd7;

  logic [2:0] st_r;
  logic       ov_r;
  logic       accept;
  logic       out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (st_r != C_IDLE);
  assign out_valid = ov_r;
  // The output register can take a new result when empty or being read.
  assign out_free  = !ov_r || !out_stall;

  // Command decode per state; issued only when the datapath is idle.
  always_comb begin
    cmd.start = 1'b0;
    cmd.cmd   = mau_pkg::DP_NOP;
    capture   = 1'b0;
    unique case (st_r)
      C_IDLE: if (accept) begin cmd.start = 1'b1; cmd.cmd = mau_pkg::DP_LOAD; end
      C_RA:   if (!sts.busy) begin
        cmd.start = 1'b1;
        cmd.cmd = (sts.op == mau_pkg::OP_REDUCE) ? mau_pkg::DP_REDRAW : mau_pkg::DP_REDB;
      end
      C_EXEC: if (!sts.busy) begin
        cmd.start = 1'b1;
        unique case (sts.op)
          mau_pkg::OP_REDUCE: cmd.cmd = mau_pkg::DP_FIXRAW;
          mau_pkg::OP_MUL:    cmd.cmd = mau_pkg::DP_MUL;
          mau_pkg::OP_DIV:    cmd.cmd = mau_pkg::DP_INVB;
          mau_pkg::OP_INV:    cmd.cmd = mau_pkg::DP_INVA;
          mau_pkg::OP_POW:    begin cmd.start = 1'b0; end
          default:            cmd.cmd = mau_pkg::DP_SIMPLE;
        endcase
      end
      C_POW: if (!sts.busy && !sts.exp_done) begin
        cmd.start = 1'b1;
        cmd.cmd = sts.exp_bit ? mau_pkg::DP_MUL : mau_pkg::DP_SQR;
      end
      C_SQ: if (!sts.busy) begin cmd.start = 1'b1; cmd.cmd = mau_pkg::DP_SQR; end
      C_DONE: capture = !sts.busy && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (capture) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (st_r)
        C_IDLE: if (accept) st_r <= C_RA;
        C_RA:   if (!sts.busy) st_r <= (sts.op == mau_pkg::OP_REDUCE) ? C_EXEC : C_RB;
        C_RB:   if (!sts.busy) st_r <= C_EXEC;
        C_EXEC: if (!sts.busy) st_r <= (sts.op == mau_pkg::OP_POW) ? C_POW : C_DONE;
        C_POW:  if (!sts.busy) begin
          if (sts.exp_done) st_r <= C_DONE;
          else if (sts.exp_bit) st_r <= C_SQ;
        end
        C_SQ:   if (!sts.busy) st_r <= C_POW;
        C_FIX:  st_r <= C_DONE;
        C_DONE: if (capture) st_r <= C_IDLE;
        default: st_r <= C_IDLE;
      endcase
    end
  end

  // A result is presented only once the datapath has gone quiet.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> !sts.busy) else $error("result raised while datapath busy");
  // A waiting result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    capture |-> out_free) else $error("result overwritten while held");
  // A result held under stall stays valid.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r) else $error("stalled result dropped");

endmodule

>>> sv/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit: controller, datapath and output register.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | mau_pkg::in_item_t
//  out     | output    | out_valid/out_stall | mau_pkg::out_item_t
//  cfg     | input     | cfg_we              | 31-bit modulus
//
// One item at a time through the shared one-bit-per-cycle divider: the next item is
// taken only once the current one's result is stored.
// Inverse and divide: one division per Euclid step, up to about 46 steps.
// Power: up to 126 multiplies for a 63-bit exponent.
// Synchronous reset loads 1000000007; a held result lets the next item run,
// and the input stalls until that item's result can be stored.
module modular_arithmetic_unit #(
  parameter int unsigned EXP_BITS = mau_pkg::EXP_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mau_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mau_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [mau_pkg::MOD_W-1:0] cfg_data
);

  logic [mau_pkg::MOD_W-1:0] modulus_r;
  mau_pkg::dp_cmd_t   cmd;
  mau_pkg::dp_sts_t   sts;
  mau_pkg::out_item_t res;
  mau_pkg::out_item_t out_r;
  logic               capture;

  // Modulus register.
  always_ff @(posedge clk) begin
    if (!rst_n) modulus_r <= mau_pkg::MODULUS_RESET;
    else if (cfg_we) modulus_r <= cfg_data;
  end

  mau_control u_ctl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd, .capture
  );

  mau_datapath #(.EXP_BITS(EXP_BITS)) u_dp (
    .clk, .rst_n, .modulus(modulus_r), .item(in_item), .cmd, .sts, .res
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (capture) out_r <= res;
  end

  assign out_item = out_r;

endmodule
